[sv/irppt_pkg.sv]
`timescale 1ns / 1ps

package irppt_pkg;

    // Request kinds carried in req_type.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    // Segment lengths in one millisecond ticks.
    localparam logic [6:0] PRE_ON_TICKS      = 7'd3;
    localparam logic [6:0] PRE_OFF_TICKS     = 7'd6;
    localparam logic [6:0] SYNC_NORMAL_TICKS = 7'd3;
    localparam logic [6:0] SYNC_BEACON_TICKS = 7'd6;
    localparam logic [6:0] BIT_GAP_TICKS     = 7'd2;
    localparam logic [6:0] BIT_ZERO_TICKS    = 7'd1;
    localparam logic [6:0] BIT_ONE_TICKS     = 7'd2;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_PRE_OFF  = 3'd1,
        PH_SYNC     = 3'd2,
        PH_BIT_GAP  = 3'd3,
        PH_BIT_MARK = 3'd4,
        PH_PAUSE    = 3'd5
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic       beacon_header;
        logic [1:0] bit_count_code;
        logic [1:0] pause_code;
        logic [8:0] payload;
    } t_in_item;

    typedef struct packed {
        logic led_on;
        logic accepted;
        logic busy_res;
    } t_out_item;

    function automatic logic [3:0] bit_count(input logic [1:0] code);
        logic [3:0] v;
        case (code)
            2'd0:    v = 4'd5;
            2'd1:    v = 4'd7;
            2'd2:    v = 4'd8;
            default: v = 4'd9;
        endcase
        return v;
    endfunction

    // Code three falls back to the longest pause.
    function automatic logic [6:0] pause_ticks(input logic [1:0] code);
        logic [6:0] v;
        case (code)
            2'd0:    v = 7'd25;
            2'd1:    v = 7'd56;
            default: v = 7'd80;
        endcase
        return v;
    endfunction

endpackage

[sv/irppt_core.sv]
`timescale 1ns / 1ps

module irppt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  irppt_pkg::t_in_item i_item,
    output irppt_pkg::t_out_item o_result
);

    logic [6:0]        r_tick_timer, n_tick_timer;
    irppt_pkg::t_phase r_phase, n_phase;
    logic              r_sending, n_sending;
    logic [8:0]        r_shift_data, n_shift_data;
    logic [3:0]        r_bits_left, n_bits_left;
    logic              r_held_header, n_held_header;
    logic [1:0]        r_held_bit_code, n_held_bit_code;
    logic [1:0]        r_held_pause_code, n_held_pause_code;
    logic              r_led_level, n_led_level;

    logic       is_tick;
    logic       taken;
    logic [6:0] timer_dec;
    logic       seg_start;
    logic [3:0] bits_dec;

    assign is_tick   = (i_item.req_type == irppt_pkg::REQ_TICK);
    assign taken     = i_step && !is_tick && !r_sending;
    assign timer_dec = (r_tick_timer != 7'd0) ? (r_tick_timer - 7'd1) : 7'd0;
    assign seg_start = i_step && is_tick && r_sending && (timer_dec == 7'd0);
    assign bits_dec  = r_bits_left - 4'd1;

    // Next segment of the packet.
    always_comb begin
        n_phase = r_phase;
        if (taken) begin
            n_phase = irppt_pkg::PH_START;
        end else if (seg_start) begin
            case (r_phase)
                irppt_pkg::PH_START:    n_phase = irppt_pkg::PH_PRE_OFF;
                irppt_pkg::PH_PRE_OFF:  n_phase = irppt_pkg::PH_SYNC;
                irppt_pkg::PH_SYNC:     n_phase = irppt_pkg::PH_BIT_GAP;
                irppt_pkg::PH_BIT_GAP:  n_phase = irppt_pkg::PH_BIT_MARK;
                irppt_pkg::PH_BIT_MARK: begin
                    n_phase = (bits_dec != 4'd0) ? irppt_pkg::PH_BIT_GAP
                                                 : irppt_pkg::PH_PAUSE;
                end
                default:                n_phase = irppt_pkg::PH_START;
            endcase
        end
    end

    // Timer, LED and data path for the segment being started.
    always_comb begin
        n_tick_timer      = r_tick_timer;
        n_sending         = r_sending;
        n_shift_data      = r_shift_data;
        n_bits_left       = r_bits_left;
        n_held_header     = r_held_header;
        n_held_bit_code   = r_held_bit_code;
        n_held_pause_code = r_held_pause_code;
        n_led_level       = r_led_level;
        if (taken) begin
            n_held_header     = i_item.beacon_header;
            n_held_bit_code   = i_item.bit_count_code;
            n_held_pause_code = i_item.pause_code;
            n_shift_data      = i_item.payload;
            n_sending         = 1'b1;
        end else if (i_step && is_tick) begin
            n_tick_timer = timer_dec;
            if (seg_start) begin
                case (r_phase)
                    irppt_pkg::PH_START: begin
                        n_led_level  = 1'b1;
                        n_tick_timer = irppt_pkg::PRE_ON_TICKS;
                    end
                    irppt_pkg::PH_PRE_OFF: begin
                        n_led_level  = 1'b0;
                        n_tick_timer = irppt_pkg::PRE_OFF_TICKS;
                    end
                    irppt_pkg::PH_SYNC: begin
                        n_led_level  = 1'b1;
                        n_tick_timer = r_held_header ? irppt_pkg::SYNC_BEACON_TICKS
                                                     : irppt_pkg::SYNC_NORMAL_TICKS;
                        n_bits_left  = irppt_pkg::bit_count(r_held_bit_code);
                    end
                    irppt_pkg::PH_BIT_GAP: begin
                        n_led_level  = 1'b0;
                        n_tick_timer = irppt_pkg::BIT_GAP_TICKS;
                    end
                    irppt_pkg::PH_BIT_MARK: begin
                        n_led_level  = 1'b1;
                        n_tick_timer = r_shift_data[0] ? irppt_pkg::BIT_ONE_TICKS
                                                       : irppt_pkg::BIT_ZERO_TICKS;
                        n_bits_left  = bits_dec;
                        if (bits_dec != 4'd0) begin
                            n_shift_data = {1'b0, r_shift_data[8:1]};
                        end
                    end
                    irppt_pkg::PH_PAUSE: begin
                        // Busy drops here while the final pause still runs.
                        n_tick_timer = irppt_pkg::pause_ticks(r_held_pause_code);
                        n_led_level  = 1'b0;
                        n_sending    = 1'b0;
                    end
                    default: begin
                        n_led_level = 1'b0;
                        n_sending   = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_timer      <= 7'd0;
            r_phase           <= irppt_pkg::PH_START;
            r_sending         <= 1'b0;
            r_shift_data      <= 9'd0;
            r_bits_left       <= 4'd0;
            r_held_header     <= 1'b0;
            r_held_bit_code   <= 2'd0;
            r_held_pause_code <= 2'd0;
            r_led_level       <= 1'b0;
        end else begin
            r_tick_timer      <= n_tick_timer;
            r_phase           <= n_phase;
            r_sending         <= n_sending;
            r_shift_data      <= n_shift_data;
            r_bits_left       <= n_bits_left;
            r_held_header     <= n_held_header;
            r_held_bit_code   <= n_held_bit_code;
            r_held_pause_code <= n_held_pause_code;
            r_led_level       <= n_led_level;
        end
    end

    assign o_result.led_on   = n_led_level;
    assign o_result.accepted = taken;
    assign o_result.busy_res = n_sending;

endmodule

[sv/ir_pulse_packet_transmitter_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (irppt_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_data (irppt_pkg::t_out_item)
//
// One request enters every cycle while the output is not stalled; its result leaves from the output register.
// The request is registered, applied to the packet state in one pass, and the
// result is registered. Reset is synchronous, active low, and clears all but the data registers.
// A stalled output holds the pipeline; a request is taken whenever the input
// register is empty or moves on in the same cycle.

module ir_pulse_packet_transmitter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  irppt_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output irppt_pkg::t_out_item o_out_data
);

    logic                 r_in_valid;
    irppt_pkg::t_in_item  r_in_data;
    logic                 r_out_valid;
    irppt_pkg::t_out_item r_out_data;
    irppt_pkg::t_out_item core_result;
    logic                 advance;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    irppt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && advance),
        .i_item   (r_in_data),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (r_in_valid && advance) begin
            r_out_data <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sim/ir_pulse_packet_transmitter_top_test.sv]
`timescale 1ns / 1ps

module ir_pulse_packet_transmitter_top_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 12;
    localparam int IN_BITS      = $bits(irppt_pkg::t_in_item);
    localparam int DIR_ROWS     = 16;

    localparam logic TICK = irppt_pkg::REQ_TICK;
    localparam logic SEND = irppt_pkg::REQ_SEND;

    typedef struct packed {
        irppt_pkg::t_in_item  item;
        logic [7:0]           reps;
        logic                 typed;
        irppt_pkg::t_out_item want;
    } t_dir_row;

    typedef struct packed {
        irppt_pkg::t_in_item  item;
        logic                 typed;
        irppt_pkg::t_out_item want;
    } t_send_entry;

    // Fields of want: led_on, accepted, busy_res.
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b0}},
        '{'{TICK, 1'b1, 2'd3, 2'd3, 9'h1FF}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b0}},
        '{'{SEND, 1'b1, 2'd3, 2'd3, 9'h1FF}, 8'd1,   1'b1, '{1'b0, 1'b1, 1'b1}},
        '{'{SEND, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd1,   1'b1, '{1'b0, 1'b0, 1'b1}},
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd1,   1'b1, '{1'b1, 1'b0, 1'b1}},
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd140, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{SEND, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd1,   1'b1, '{1'b0, 1'b1, 1'b1}},
        '{'{TICK, 1'b1, 2'd1, 2'd2, 9'h0F0}, 8'd40,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{SEND, 1'b0, 2'd1, 2'd2, 9'h0AA}, 8'd1,   1'b1, '{1'b0, 1'b1, 1'b1}},
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd150, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{SEND, 1'b1, 2'd2, 2'd1, 9'h155}, 8'd1,   1'b1, '{1'b0, 1'b1, 1'b1}},
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{SEND, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd1,   1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd120, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{SEND, 1'b0, 2'd3, 2'd2, 9'h100}, 8'd1,   1'b0, '{1'b0, 1'b0, 1'b0}},
        '{'{TICK, 1'b0, 2'd0, 2'd0, 9'h000}, 8'd200, 1'b0, '{1'b0, 1'b0, 1'b0}}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    irppt_pkg::t_in_item  in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    irppt_pkg::t_out_item out_data;

    t_send_entry          request_stream[$];
    irppt_pkg::t_out_item expected_led_status[$];
    t_send_entry          in_flight;
    irppt_pkg::t_out_item predicted;
    irppt_pkg::t_out_item oldest_status;
    int                   gap_left    = 0;
    int                   burst_left  = 1;
    int                   cycle_count = 0;
    int                   errors      = 0;

    // Shadow copy of the transmitter state.
    logic [6:0]        tx_timer      = '0;
    irppt_pkg::t_phase tx_phase      = irppt_pkg::PH_START;
    logic              tx_sending    = 1'b0;
    logic [8:0]        tx_shift      = '0;
    logic [3:0]        tx_bits_left  = '0;
    logic              tx_header     = 1'b0;
    logic [1:0]        tx_bit_code   = '0;
    logic [1:0]        tx_pause_code = '0;
    logic              tx_led        = 1'b0;

    ir_pulse_packet_transmitter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic irppt_pkg::t_out_item advance_transmitter(
        input irppt_pkg::t_in_item req
    );
        irppt_pkg::t_out_item res;
        res = '0;
        if (req.req_type == irppt_pkg::REQ_TICK) begin
            if (tx_timer != 7'd0) begin
                tx_timer = tx_timer - 7'd1;
            end
            if (tx_sending && tx_timer == 7'd0) begin
                case (tx_phase)
                    irppt_pkg::PH_START: begin
                        tx_led   = 1'b1;
                        tx_timer = irppt_pkg::PRE_ON_TICKS;
                        tx_phase = irppt_pkg::PH_PRE_OFF;
                    end
                    irppt_pkg::PH_PRE_OFF: begin
                        tx_led   = 1'b0;
                        tx_timer = irppt_pkg::PRE_OFF_TICKS;
                        tx_phase = irppt_pkg::PH_SYNC;
                    end
                    irppt_pkg::PH_SYNC: begin
                        tx_led   = 1'b1;
                        tx_timer = tx_header ? irppt_pkg::SYNC_BEACON_TICKS
                                             : irppt_pkg::SYNC_NORMAL_TICKS;
                        case (tx_bit_code)
                            2'd0:    tx_bits_left = 4'd5;
                            2'd1:    tx_bits_left = 4'd7;
                            2'd2:    tx_bits_left = 4'd8;
                            default: tx_bits_left = 4'd9;
                        endcase
                        tx_phase = irppt_pkg::PH_BIT_GAP;
                    end
                    irppt_pkg::PH_BIT_GAP: begin
                        tx_led   = 1'b0;
                        tx_timer = irppt_pkg::BIT_GAP_TICKS;
                        tx_phase = irppt_pkg::PH_BIT_MARK;
                    end
                    irppt_pkg::PH_BIT_MARK: begin
                        tx_led       = 1'b1;
                        tx_timer     = tx_shift[0] ? irppt_pkg::BIT_ONE_TICKS
                                                   : irppt_pkg::BIT_ZERO_TICKS;
                        tx_bits_left = tx_bits_left - 4'd1;
                        if (tx_bits_left != 4'd0) begin
                            tx_shift = tx_shift >> 1;
                            tx_phase = irppt_pkg::PH_BIT_GAP;
                        end else begin
                            tx_phase = irppt_pkg::PH_PAUSE;
                        end
                    end
                    default: begin
                        // The final pause is loaded only from the pause phase;
                        // any other value just ends the packet.
                        if (tx_phase == irppt_pkg::PH_PAUSE) begin
                            case (tx_pause_code)
                                2'd0:    tx_timer = 7'd25;
                                2'd1:    tx_timer = 7'd56;
                                default: tx_timer = 7'd80;
                            endcase
                        end
                        tx_led     = 1'b0;
                        tx_sending = 1'b0;
                        tx_phase   = irppt_pkg::PH_START;
                    end
                endcase
            end
        end else if (!tx_sending) begin
            tx_header     = req.beacon_header;
            tx_bit_code   = req.bit_count_code;
            tx_pause_code = req.pause_code;
            tx_shift      = req.payload;
            tx_phase      = irppt_pkg::PH_START;
            tx_sending    = 1'b1;
            res.accepted  = 1'b1;
        end
        res.led_on   = tx_led;
        res.busy_res = tx_sending;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Request side: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predicted = advance_transmitter(in_flight.item);
                expected_led_status.push_back(in_flight.typed ? in_flight.want : predicted);
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (request_stream.size() > 0) begin
                    in_flight = request_stream.pop_front();
                    in_data  <= in_flight.item;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: stalls at random only while bit 8 of the cycle count is set.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_led_status.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    oldest_status = expected_led_status.pop_front();
                    if (out_data.led_on !== oldest_status.led_on) begin
                        report_mismatch($sformatf("led_on got %b want %b",
                                                  out_data.led_on, oldest_status.led_on));
                    end
                    if (out_data.accepted !== oldest_status.accepted) begin
                        report_mismatch($sformatf("accepted got %b want %b",
                                                  out_data.accepted, oldest_status.accepted));
                    end
                    if (out_data.busy_res !== oldest_status.busy_res) begin
                        report_mismatch($sformatf("busy_res got %b want %b",
                                                  out_data.busy_res, oldest_status.busy_res));
                    end
                end
            end
            out_ready <= !(cycle_count[8] && ($urandom_range(0, 2) == 0));
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        irppt_pkg::t_in_item it;
        int                  n_items;
        int                  ticks;
        n_items = 0;
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                request_stream.push_back(t_send_entry'{DIRECTED[r].item, DIRECTED[r].typed,
                                                       DIRECTED[r].want});
            end
        end
        // Mostly one request followed by a long run of ticks, often enough to play it out.
        // Some tick runs are cut short, and stray requests land mid-packet.
        while (n_items < RANDOM_ITEMS) begin
            it = irppt_pkg::t_in_item'(IN_BITS'($urandom));
            it.req_type = irppt_pkg::REQ_SEND;
            request_stream.push_back(t_send_entry'{it, 1'b0, '0});
            n_items++;
            ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                : $urandom_range(60, 170);
            repeat (ticks) begin
                it = irppt_pkg::t_in_item'(IN_BITS'($urandom));
                it.req_type = ($urandom_range(0, 39) == 0) ? irppt_pkg::REQ_SEND
                                                           : irppt_pkg::REQ_TICK;
                request_stream.push_back(t_send_entry'{it, 1'b0, '0});
                n_items++;
            end
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (request_stream.size() == 0 && !in_valid && expected_led_status.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/irppt_pkg.sv
sv/irppt_core.sv
sv/ir_pulse_packet_transmitter_top.sv
sim/ir_pulse_packet_transmitter_top_test.sv
